/* rtl/core/gsc_pkg.sv */
package gsc_pkg;

   // Request kinds carried in the request beat's tuser.
   localparam logic [1:0] REQ_RUN     = 2'd0;
   localparam logic [1:0] REQ_DOCK    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // Register indexes on the configuration port (byte address is 4 * index).
   localparam logic [1:0] REG_PRESENT_HOLD = 2'd0;
   localparam logic [1:0] REG_ABSENT_HOLD  = 2'd1;
   localparam logic [1:0] REG_CLOSE_DELAY  = 2'd2;
   localparam logic [1:0] REG_PRESENT_LVL  = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [15:0] PRESENT_HOLD_RST = 16'd20;
   localparam logic [15:0] ABSENT_HOLD_RST  = 16'd300;
   localparam logic [15:0] CLOSE_DELAY_RST  = 16'd200;
   localparam logic        PRESENT_LVL_RST  = 1'b0;

   // Reported sequence state codes.
   localparam logic [1:0] CODE_IDLE    = 2'd0;
   localparam logic [1:0] CODE_WAIT    = 2'd1;
   localparam logic [1:0] CODE_UPRIGHT = 2'd2;
   localparam logic [1:0] CODE_DOCKED  = 2'd3;

   // Sequencer state, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_WAIT    = 4'b0010,
      ST_UPRIGHT = 4'b0100,
      ST_DOCKED  = 4'b1000
   } seq_state_type;

   // Configuration as seen by the step logic.
   typedef struct packed {
      logic [15:0] present_hold_ms;
      logic [15:0] absent_hold_ms;
      logic [15:0] close_delay_ms;
      logic        present_level;
   } gsc_cfg_type;

   // Map the one-hot state onto the two-bit code of the result beat.
   function automatic logic [1:0] state_code(input seq_state_type st);
      logic [1:0] code;
      case (st)
         ST_IDLE:    code = CODE_IDLE;
         ST_WAIT:    code = CODE_WAIT;
         ST_UPRIGHT: code = CODE_UPRIGHT;
         ST_DOCKED:  code = CODE_DOCKED;
         default:    code = CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* rtl/core/gsc_csr.sv */
module gsc_csr
   import gsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output gsc_cfg_type cfg
);

   gsc_cfg_type cfg_ff;
   gsc_cfg_type cfg_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PRESENT_HOLD: cfg_in.present_hold_ms = csr_pwdata[15:0];
            REG_ABSENT_HOLD:  cfg_in.absent_hold_ms  = csr_pwdata[15:0];
            REG_CLOSE_DELAY:  cfg_in.close_delay_ms  = csr_pwdata[15:0];
            REG_PRESENT_LVL:  cfg_in.present_level   = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.present_hold_ms <= PRESENT_HOLD_RST;
         cfg_ff.absent_hold_ms  <= ABSENT_HOLD_RST;
         cfg_ff.close_delay_ms  <= CLOSE_DELAY_RST;
         cfg_ff.present_level   <= PRESENT_LVL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux.
   always_comb begin
      case (reg_idx)
         REG_PRESENT_HOLD: csr_prdata = {16'd0, cfg_ff.present_hold_ms};
         REG_ABSENT_HOLD:  csr_prdata = {16'd0, cfg_ff.absent_hold_ms};
         REG_CLOSE_DELAY:  csr_prdata = {16'd0, cfg_ff.close_delay_ms};
         REG_PRESENT_LVL:  csr_prdata = {31'd0, cfg_ff.present_level};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/gripper_sequence_controller.sv */
// Channel   Direction  tdata (low bit up)                       tuser
// req       in         now_ms[31:0], switch_raw[32], pad to 40  req_type[1:0]
// rsp       out        servo_upright[0], clamp_closed[1],       none
//                      seq_state[3:2], pad to 8
// csr       in/out     APB register port, registers at 4*index  none
//
// One beat per cycle is sustained while the result channel is not stalled. A request
// beat is captured in the input register, its step is evaluated against the
// sequencer state and the result lands in the output register.
// Reset is synchronous and returns the sequencer, tracker and registers to
// their reset values. A stalled result holds the output register; the input
// register still takes a beat while it is empty.
module gripper_sequence_controller
   import gsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ms[31:0], switch_raw[32], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // servo_upright[0], clamp_closed[1], seq_state[3:2]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   gsc_cfg_type cfg;

   gsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Input register.
   logic        in_valid_ff;
   logic [1:0]  in_type_ff;
   logic [31:0] in_now_ff;
   logic        in_raw_ff;

   // Output register.
   logic        out_valid_ff;
   logic [3:0]  out_data_ff;

   // Sequencer and tracker state.
   seq_state_type state_ff, state_in;
   logic [31:0]   close_start_ff, close_start_in;
   logic          tracked_ff, tracked_in;
   logic [31:0]   since_ff, since_in;
   logic          servo_ff, servo_in;
   logic          clamp_ff, clamp_in;

   logic req_fire;
   logic advance;
   logic step;

   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign req_fire   = req_tvalid & req_tready;
   assign step       = in_valid_ff & advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_type_ff <= req_tuser;
         in_now_ff  <= req_tdata[31:0];
         in_raw_ff  <= req_tdata[32];
      end
   end

   // Step logic: tracker update, hold checks and sequencer transitions.
   logic [31:0] lvl_age;
   logic [31:0] close_age;
   logic        absent_lvl;
   logic        present_ok;
   logic        absent_ok;
   logic        trk_lvl;
   logic [31:0] trk_since;

   always_comb begin
      absent_lvl = ~cfg.present_level;
      // The tracker restarts its timer whenever the raw level changes.
      if (in_raw_ff != tracked_ff) begin
         trk_lvl   = in_raw_ff;
         trk_since = in_now_ff;
      end else begin
         trk_lvl   = tracked_ff;
         trk_since = since_ff;
      end
      lvl_age    = in_now_ff - trk_since;
      close_age  = in_now_ff - close_start_ff;
      // A zero hold time passes on the level alone since the age is never below it.
      present_ok = (trk_lvl == cfg.present_level) &&
                   (lvl_age >= {16'd0, cfg.present_hold_ms});
      absent_ok  = (trk_lvl == absent_lvl) &&
                   (lvl_age >= {16'd0, cfg.absent_hold_ms});

      state_in       = state_ff;
      close_start_in = close_start_ff;
      tracked_in     = tracked_ff;
      since_in       = since_ff;
      servo_in       = servo_ff;
      clamp_in       = clamp_ff;

      case (in_type_ff)
         REQ_RUN: begin
            tracked_in = trk_lvl;
            since_in   = trk_since;
            case (state_ff)
               ST_IDLE: begin
                  servo_in = 1'b0;
                  clamp_in = 1'b0;
                  if (present_ok) begin
                     clamp_in       = 1'b1;
                     close_start_in = in_now_ff;
                     state_in       = ST_WAIT;
                  end
               end
               ST_WAIT: begin
                  if (absent_ok) begin
                     clamp_in = 1'b0;
                     state_in = ST_IDLE;
                  end else if (close_age >= {16'd0, cfg.close_delay_ms}) begin
                     servo_in = 1'b1;
                     state_in = ST_UPRIGHT;
                  end
               end
               ST_UPRIGHT: begin
                  servo_in = 1'b1;
                  clamp_in = ~absent_ok;
                  if (absent_ok) begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  servo_in = 1'b1;
                  clamp_in = 1'b0;
               end
            endcase
         end
         REQ_DOCK: begin
            if (state_ff == ST_UPRIGHT) begin
               servo_in = 1'b1;
               clamp_in = 1'b0;
               state_in = ST_DOCKED;
            end
         end
         REQ_RESTART: begin
            state_in       = ST_IDLE;
            close_start_in = 32'd0;
            tracked_in     = in_raw_ff;
            since_in       = in_now_ff;
            servo_in       = 1'b0;
            clamp_in       = 1'b0;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         close_start_ff <= 32'd0;
         tracked_ff     <= 1'b1;
         since_ff       <= 32'd0;
         servo_ff       <= 1'b0;
         clamp_ff       <= 1'b0;
      end else if (step) begin
         state_ff       <= state_in;
         close_start_ff <= close_start_in;
         tracked_ff     <= tracked_in;
         since_ff       <= since_in;
         servo_ff       <= servo_in;
         clamp_ff       <= clamp_in;
      end
   end

   // Result register: loads with the step, drains on a taken beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= {state_code(state_in), clamp_in, servo_in};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_data_ff};

   // The clamp is closed exactly while waiting or holding upright.
   a_clamp_matches_state: assert property (@(posedge clock) disable iff (reset)
      clamp_ff == ((state_ff == ST_WAIT) || (state_ff == ST_UPRIGHT)))
      else $error("clamp command disagrees with sequencer state");

   // Upright hold and docked always command the servo upright.
   a_servo_upright: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPRIGHT) || (state_ff == ST_DOCKED)) |-> servo_ff)
      else $error("servo not upright in upright or docked state");

   // Docked is entered only from upright hold.
   a_dock_entry: assert property (@(posedge clock) disable iff (reset)
      (step && state_in == ST_DOCKED && state_ff != ST_DOCKED) |->
      (state_ff == ST_UPRIGHT && in_type_ff == REQ_DOCK))
      else $error("docked entered from a state other than upright hold");

   // A beat held in the input register is never dropped while the output stalls.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input beat lost during output stall");

endmodule
